// ===== rtl/ndd_pkg.sv =====
`timescale 1ns / 1ps
package ndd_pkg;

  // Store geometry and number format.
  localparam int MaxPoints = 16;
  localparam int FracBits  = 16;
  localparam int AddrW     = $clog2(MaxPoints);
  localparam int CountW    = $clog2(MaxPoints + 1);

  // Numerator bits of a divided difference: 33-bit magnitude shifted by FracBits.
  localparam int NumW = 33 + FracBits;
  localparam int DenW = 33;

  localparam logic [31:0] EvalReset = 32'(64'd13 << FracBits);
  localparam logic [31:0] One       = 32'(64'd1 << FracBits);

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_SAT  = 2'd2,
    ST_OVER = 2'd3
  } status_t;

  // Divider request from the sequencer.
  typedef struct packed {
    logic            go;
    logic [NumW-1:0] num_mag;
    logic [DenW-1:0] den_mag;
    logic            neg;
  } div_req_t;

  // Divider response.
  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic        sat;
  } div_rsp_t;

  // Saturate a 64-bit signed value to 32 bits.
  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    logic [32:0] r;
    if (v > 64'sd2147483647) r = {1'b1, 32'h7fffffff};
    else if (v < -64'sd2147483648) r = {1'b1, 32'h80000000};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

endpackage

// ===== rtl/ndd_div.sv =====
`timescale 1ns / 1ps
module ndd_div (
  input  logic              clk,
  input  logic              rst,
  input  ndd_pkg::div_req_t req,
  output ndd_pkg::div_rsp_t rsp
);
  import ndd_pkg::*;

  localparam int StepW = $clog2(NumW + 1);

  logic [NumW-1:0]  quo;
  logic [DenW:0]    rem;
  logic [DenW-1:0]  den;
  logic             neg;
  logic [StepW-1:0] steps;
  logic             running;
  logic [DenW:0]    trial;
  logic             done;
  logic signed [63:0] sq;
  logic [32:0]      s;

  // One quotient bit per cycle, restoring.
  assign trial = {rem[DenW-1:0], quo[NumW-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        running <= 1'b1;
        quo     <= req.num_mag;
        rem     <= '0;
        den     <= req.den_mag;
        neg     <= req.neg;
        steps   <= StepW'(NumW);
      end else if (running) begin
        if (trial[DenW]) begin
          rem <= {rem[DenW-1:0], quo[NumW-1]};
          quo <= {quo[NumW-2:0], 1'b0};
        end else begin
          rem <= trial;
          quo <= {quo[NumW-2:0], 1'b1};
        end
        steps <= steps - 1'b1;
        if (steps == StepW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Apply sign and saturate the finished quotient.
  always_comb begin
    if (|quo[NumW-1:40]) sq = neg ? -64'sd4294967296 : 64'sd4294967296;
    else sq = neg ? -$signed(64'(quo[39:0])) : $signed(64'(quo[39:0]));
    s = sat32(sq);
    rsp.done = done;
    rsp.quot = s[31:0];
    rsp.sat  = s[32];
  end

endmodule

// ===== rtl/ndd_mul.sv =====
`timescale 1ns / 1ps
module ndd_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] prod,
  output logic        sat
);
  import ndd_pkg::*;

  logic [31:0] ma, mb;
  logic        neg, neg_q;
  logic [63:0] mp;
  logic [63:0] sh;
  logic signed [63:0] r;
  logic [32:0] s;

  assign ma  = a[31] ? 32'(-a) : a;
  assign mb  = b[31] ? 32'(-b) : b;
  assign neg = a[31] ^ b[31];

  // Magnitude product registered before the scale and saturate.
  always_ff @(posedge clk) begin
    mp    <= 64'(ma) * 64'(mb);
    neg_q <= neg;
  end

  always_comb begin
    sh = mp >> FracBits;
    if (|sh[63:40]) r = neg_q ? -64'sd4294967296 : 64'sd4294967296;
    else r = neg_q ? -$signed(64'(sh[39:0])) : $signed(64'(sh[39:0]));
    s = sat32(r);
    prod = s[31:0];
    sat  = s[32];
  end

endmodule

// ===== rtl/newton_divided_difference_interp.sv =====
`timescale 1ns / 1ps
// Points load one per cycle while idle; the point with last_point set starts
// the solve, during which busy is high and the result appears as a one-cycle
// done strobe on interp_value and status that cannot be held off. The solve
// runs n(n-1)/2 divided differences, each two store reads, a divider launch
// and the wait on the one-bit-per-cycle divider; a duplicate x ends it early.
// It then runs n-1 evaluation steps (ERD, EM1 to EM4) through one pipelined
// multiplier, and ERD, EM1 and OUT to finish and present the result.
module newton_divided_difference_interp (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] sample_x,
  input  logic [31:0] sample_y,
  input  logic        last_point,
  output logic        done,
  output logic [31:0] interp_value,
  output logic [1:0]  status
);
  import ndd_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_RDA  = 11'b00000000010,
    S_RDB  = 11'b00000000100,
    S_DIV  = 11'b00000001000,
    S_WAIT = 11'b00000010000,
    S_ERD  = 11'b00000100000,
    S_EM1  = 11'b00001000000,
    S_EM2  = 11'b00010000000,
    S_EM3  = 11'b00100000000,
    S_EM4  = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_t;

  state_t state;
  logic [31:0] eval_point;
  logic [CountW-1:0] point_count;
  logic overflow_seen, sat_seen, dup;
  logic [AddrW-1:0] k, j;

  // Stores.
  logic [31:0] xmem [MaxPoints];
  logic [31:0] cmem [MaxPoints];
  logic [AddrW-1:0] ra, rc;
  logic [31:0] xq, cq;
  logic we;
  logic [AddrW-1:0] wa;
  logic [31:0] wx, wc;
  logic wxen;

  logic [31:0] xa, ca, xb;
  logic [31:0] acc, p, d, mprod;
  logic        msat;
  logic [31:0] ma, mb;
  div_req_t dreq;
  div_rsp_t drsp;

  logic signed [63:0] den, num, dsub, asum;
  logic [32:0] ds, as;

  assign pready = 1'b1;
  assign prdata = eval_point;
  assign busy   = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (we) begin
      cmem[wa] <= wc;
      if (wxen) xmem[wa] <= wx;
    end
    xq <= xmem[ra];
    cq <= cmem[rc];
  end

  ndd_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));
  ndd_mul u_mul (.clk(clk), .a(ma), .b(mb), .prod(mprod), .sat(msat));

  // Difference terms.
  always_comb begin
    den  = $signed(64'(signed'(xa))) - $signed(64'(signed'(xq)));
    num  = $signed(64'(signed'(ca))) - $signed(64'(signed'(cq)));
    dsub = $signed(64'(signed'(eval_point))) - $signed(64'(signed'(xq)));
    ds   = sat32(dsub);
    asum = $signed(64'(signed'(acc))) + $signed(64'(signed'(mprod)));
    as   = sat32(asum);
    dreq.go      = (state == S_DIV);
    dreq.neg     = num[63] ^ den[63];
    dreq.num_mag = NumW'((num[63] ? 64'(-num) : 64'(num)) << FracBits);
    dreq.den_mag = DenW'(den[63] ? 64'(-den) : 64'(den));
  end

  // Multiplier operands by step; the coefficient takes the fresh basis product.
  always_comb begin
    ma = p;
    mb = d;
    if (state == S_EM3) begin
      ma = xb;
      mb = mprod;
    end
  end

  // Store port control.
  always_comb begin
    we = 1'b0;
    wxen = 1'b0;
    wa = j;
    wx = sample_x;
    wc = sample_y;
    ra = j;
    rc = j;
    unique case (state)
      S_IDLE: begin
        we = start && (point_count < CountW'(MaxPoints));
        wxen = 1'b1;
        wa = AddrW'(point_count);
      end
      S_RDA:  ra = j;
      S_RDB: begin
        ra = AddrW'(j - k);
        rc = AddrW'(j - 1'b1);
      end
      S_WAIT: begin
        we = drsp.done;
        wc = drsp.quot;
      end
      S_ERD: begin
        ra = k;
        rc = k;
      end
      S_EM1:  rc = AddrW'(k + 1'b1);
      default: ra = j;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      eval_point <= EvalReset;
      point_count <= '0;
      overflow_seen <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (psel && penable && pwrite && paddr == 2'd0) eval_point <= pwdata;
      unique case (state)
        S_IDLE: if (start) begin
          if (point_count < CountW'(MaxPoints)) point_count <= point_count + 1'b1;
          else overflow_seen <= 1'b1;
          if (last_point) begin
            sat_seen <= 1'b0;
            dup <= 1'b0;
            if (point_count < CountW'(MaxPoints))
              j <= AddrW'(point_count);
            else
              j <= AddrW'(point_count - 1'b1);
            if (point_count == '0 || (MaxPoints == 1)) begin
              k <= '0;
              state <= S_ERD;
            end else begin
              k <= AddrW'(1);
              state <= S_RDA;
            end
          end
        end
        S_RDA: state <= S_RDB;
        S_RDB: begin
          xa <= xq;
          ca <= cq;
          state <= S_DIV;
        end
        S_DIV: begin
          if (den == 0) begin
            dup <= 1'b1;
            state <= S_OUT;
          end else state <= S_WAIT;
        end
        S_WAIT: if (drsp.done) begin
          sat_seen <= sat_seen | drsp.sat;
          if (j == k) begin
            if (CountW'(k) + 1'b1 >= point_count) begin
              k <= '0;
              state <= S_ERD;
            end else begin
              k <= k + 1'b1;
              j <= AddrW'(point_count - 1'b1);
              state <= S_RDA;
            end
          end else begin
            j <= j - 1'b1;
            state <= S_RDA;
          end
        end
        S_ERD: begin
          if (k == '0) p <= One;
          state <= S_EM1;
        end
        S_EM1: begin
          if (point_count == '0) begin
            acc <= '0;
            state <= S_OUT;
          end else begin
            if (k == '0) acc <= cq;
            if (CountW'(k) + 1'b1 >= point_count) state <= S_OUT;
            else begin
              d <= ds[31:0];
              sat_seen <= sat_seen | ds[32];
              state <= S_EM2;
            end
          end
        end
        S_EM2: begin
          xb <= cq;
          state <= S_EM3;
        end
        S_EM3: begin
          p <= mprod;
          sat_seen <= sat_seen | msat;
          state <= S_EM4;
        end
        S_EM4: begin
          acc <= as[31:0];
          sat_seen <= sat_seen | msat | as[32];
          k <= k + 1'b1;
          state <= S_ERD;
        end
        S_OUT: begin
          done <= 1'b1;
          if (dup) begin
            interp_value <= '0;
            status <= ST_DUP;
          end else begin
            interp_value <= acc;
            status <= overflow_seen ? ST_OVER : (sat_seen ? ST_SAT : ST_OK);
          end
          point_count <= '0;
          overflow_seen <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Evaluation keeps p across steps; ERD must not reset it after the first.
  // (p is reloaded to one only when k is zero.)

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_one_shot: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_dup_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_DUP) |-> interp_value == '0)
    else $error("duplicate x with nonzero value");

endmodule
